/* hdl/qac_pkg.sv */
`timescale 1ns / 1ps

package qac_pkg;

    localparam int FRAC_BITS = 15;
    localparam int DW        = 16;                 // component width
    localparam int SQW       = 2 * FRAC_BITS + 1;  // width of one square, unsigned Q1.30
    localparam int CURW      = SQW + 1;            // sum of three squares
    localparam int FACW      = 17;                 // Q1.16 factor, up to 1.0 inclusive
    localparam int FAC_FRAC  = 16;
    localparam int RW        = 2 * FACW + CURW + 1; // remainder / trial width
    localparam int PRW       = DW + FACW + 1;      // component times signed factor

    localparam logic [SQW-1:0]  ONE_SQ   = SQW'(1) << (2 * FRAC_BITS);
    localparam logic [FACW-1:0] FAC_UNIT = FACW'(1) << FAC_FRAC;
    localparam logic signed [DW-1:0] DW_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DW_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] scalar_part;
        logic signed [DW-1:0] vec_a;
        logic signed [DW-1:0] vec_b;
        logic signed [DW-1:0] vec_c;
        logic signed [DW-1:0] cos_half_limit;
    } qac_in_t;

    typedef struct packed {
        logic signed [DW-1:0] out_scalar;
        logic signed [DW-1:0] out_vec_a;
        logic signed [DW-1:0] out_vec_b;
        logic signed [DW-1:0] out_vec_c;
        logic                 clamped;
    } qac_out_t;

    // Item state while the scale factor is resolved bit by bit.
    typedef struct packed {
        logic signed [DW-1:0] scalar;
        logic signed [DW-1:0] va;
        logic signed [DW-1:0] vb;
        logic signed [DW-1:0] vc;
        logic                 clamped;
        logic                 en;
        logic [CURW-1:0]      cur;
        logic [RW-1:0]        rem;
        logic [RW-1:0]        fc;
        logic [FACW-1:0]      f;
    } qac_root_t;

endpackage

/* hdl/qac_root_step.sv */
`timescale 1ns / 1ps

module qac_root_step
    import qac_pkg::*;
#(
    parameter int K = 0
)
(
    input  qac_root_t d,
    output qac_root_t q
);

    logic [RW-1:0] trial;

    // (f + 2^K)^2 * cur - f^2 * cur = 2^(K+1) * f * cur + 2^(2K) * cur
    always_comb
    begin
        trial = (d.fc << (K + 1)) + (RW'(d.cur) << (2 * K));
        q     = d;
        if (trial <= d.rem)
        begin
            q.rem = d.rem - trial;
            q.fc  = d.fc + (RW'(d.cur) << K);
            q.f   = d.f | (FACW'(1) << K);
        end
    end

endmodule

/* hdl/quaternion_angle_clamp.sv */
`timescale 1ns / 1ps
// Quaternion rotation angle clamp, Q1.15 fixed point.
// Input channel in_valid/in_ready/in_data carries a quaternion (scalar_part,
// vec_a..vec_c) and the cosine of half the allowed angle. Output channel
// out_valid/out_ready/out_data returns one clamped quaternion per item plus a
// clamped flag. A transfer happens when valid and ready are both high.
// Stages in order: the squares, limit/cur and the clamp decision, the
// bit-serial scale factor search (one factor bit per stage), the vector
// scaling multiplies and shift/saturate.
// One item per cycle while out_ready is high; each stage has its own valid bit.
// When the receiver stalls, an occupied stage holds while empty stages in
// front of it keep filling, so in_ready drops only once the whole pipe is full.
// Reset clears all valid bits; payload registers are not reset.

module quaternion_angle_clamp
    import qac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  qac_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output qac_out_t out_data
);

    localparam int NROOT = FACW;       // one stage per factor bit
    localparam int NST   = NROOT + 4;  // square, decide, roots, multiply, output

    logic [NST-1:0] vld_reg;
    logic [NST:0]   adv;

    // Stage ready chain: a stage may load when it is empty or draining.
    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: squares.
    qac_in_t        s1_reg;
    logic [SQW-1:0] cc_reg, sa_reg, sb_reg, sc_reg;
    logic signed [2*DW-1:0] cc_p, sa_p, sb_p, sc_p;

    assign cc_p = in_data.cos_half_limit * in_data.cos_half_limit;
    assign sa_p = in_data.vec_a * in_data.vec_a;
    assign sb_p = in_data.vec_b * in_data.vec_b;
    assign sc_p = in_data.vec_c * in_data.vec_c;

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            s1_reg <= in_data;
            cc_reg <= cc_p[SQW-1:0];
            sa_reg <= sa_p[SQW-1:0];
            sb_reg <= sb_p[SQW-1:0];
            sc_reg <= sc_p[SQW-1:0];
        end
    end

    // Stage 1: limit, cur and the clamp decision.
    qac_root_t       dec_next;
    logic [CURW-1:0] cur;
    logic [SQW-1:0]  limit;
    logic            pass;
    logic signed [DW-1:0] neg_c;

    always_comb
    begin
        cur   = CURW'(sa_reg) + CURW'(sb_reg) + CURW'(sc_reg);
        limit = ONE_SQ - cc_reg;
        pass  = CURW'(limit) > cur;
        neg_c = (s1_reg.cos_half_limit == DW_MIN) ? DW_MAX : -s1_reg.cos_half_limit;

        dec_next.va      = s1_reg.vec_a;
        dec_next.vb      = s1_reg.vec_b;
        dec_next.vc      = s1_reg.vec_c;
        dec_next.clamped = !pass;
        dec_next.en      = (cur != '0) && (limit != '0);
        dec_next.cur     = cur;
        dec_next.rem     = RW'(limit) << (2 * FAC_FRAC);
        dec_next.fc      = '0;
        dec_next.f       = '0;
        if (pass)
        begin
            dec_next.scalar = s1_reg.scalar_part;
        end
        else if (s1_reg.scalar_part < 0)
        begin
            dec_next.scalar = neg_c;
        end
        else
        begin
            dec_next.scalar = s1_reg.cos_half_limit;
        end
    end

    // Root stages: rt_reg[0] is the decision stage, rt_reg[j] has factor bits
    // down to NROOT-j resolved.
    qac_root_t rt_reg [NROOT+1];
    qac_root_t rt_next [NROOT+1];

    assign rt_next[0] = dec_next;

    for (genvar j = 1; j <= NROOT; j++)
    begin : g_root
        qac_root_step #(
            .K (NROOT - j)
        ) u_step (
            .d (rt_reg[j-1]),
            .q (rt_next[j])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= NROOT; j++)
        begin
            if (adv[j+1] && vld_reg[j])
            begin
                rt_reg[j] <= rt_next[j];
            end
        end
    end

    // Multiply stage: an unclamped item uses a factor of exactly one.
    localparam int MS = NROOT + 2;

    qac_root_t             fin;
    logic [FACW-1:0]       fac;
    logic signed [FACW:0]  fac_s;
    logic signed [PRW-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [DW-1:0]  ps_reg;
    logic                  pcl_reg;

    always_comb
    begin
        fin = rt_reg[NROOT];
        if (!fin.clamped)
        begin
            fac = FAC_UNIT;
        end
        else if (fin.en)
        begin
            fac = fin.f;
        end
        else
        begin
            fac = '0;
        end
        fac_s = signed'({1'b0, fac});
    end

    always_ff @(posedge clk)
    begin
        if (adv[MS] && vld_reg[MS-1])
        begin
            pa_reg  <= PRW'(fin.va * fac_s);
            pb_reg  <= PRW'(fin.vb * fac_s);
            pc_reg  <= PRW'(fin.vc * fac_s);
            ps_reg  <= fin.scalar;
            pcl_reg <= fin.clamped;
        end
    end

    // Output stage: floor shift and saturate.
    function automatic logic signed [DW-1:0] sat_shift(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] sh;
        sh = p >>> FAC_FRAC;
        if (sh > PRW'(DW_MAX))
        begin
            return DW_MAX;
        end
        else if (sh < PRW'(DW_MIN))
        begin
            return DW_MIN;
        end
        return sh[DW-1:0];
    endfunction

    qac_out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NST-1] && vld_reg[NST-2])
        begin
            out_reg.out_scalar <= ps_reg;
            out_reg.out_vec_a  <= sat_shift(pa_reg);
            out_reg.out_vec_b  <= sat_shift(pb_reg);
            out_reg.out_vec_c  <= sat_shift(pc_reg);
            out_reg.clamped    <= pcl_reg;
        end
    end

    assign out_data = out_reg;

endmodule
